/* rtl/stn_pkg.sv */
// ----------------------------------------------------------------------------
// stn_pkg
// Shared types, constants and byte classification for the text normaliser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stn_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] LeadByte  = 8'hC3;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;
  localparam logic [ByteW-1:0] CaseBit   = 8'h20;
  localparam logic [ByteW-1:0] UpperLo   = 8'h41;
  localparam logic [ByteW-1:0] UpperHi   = 8'h5A;

  localparam logic [ByteW-1:0] ChA = 8'h61;
  localparam logic [ByteW-1:0] ChC = 8'h63;
  localparam logic [ByteW-1:0] ChE = 8'h65;
  localparam logic [ByteW-1:0] ChI = 8'h69;
  localparam logic [ByteW-1:0] ChN = 8'h6E;
  localparam logic [ByteW-1:0] ChO = 8'h6F;
  localparam logic [ByteW-1:0] ChU = 8'h75;
  localparam logic [ByteW-1:0] ChY = 8'h79;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       e0;
    res_t       e1;
  } push_t;

  function automatic logic is_ws(input logic [ByteW-1:0] b);
    logic r;
    case (b) inside
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: r = 1'b1;
      default:                                  r = 1'b0;
    endcase
    return r;
  endfunction

  // plain letter for the trail byte of an accented letter, zero if none
  function automatic logic [ByteW-1:0] fold_trail(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    case (b) inside
      [8'h80:8'h85], [8'hA0:8'hA5]: r = ChA;
      8'h87, 8'hA7:                 r = ChC;
      [8'h88:8'h8B], [8'hA8:8'hAB]: r = ChE;
      [8'h8C:8'h8F], [8'hAC:8'hAF]: r = ChI;
      8'h91, 8'hB1:                 r = ChN;
      [8'h92:8'h96], [8'hB2:8'hB6]: r = ChO;
      [8'h99:8'h9C], [8'hB9:8'hBC]: r = ChU;
      8'h9D, 8'hBD, 8'hBF:          r = ChY;
      default:                      r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/search_text_normalizer.sv */
// ----------------------------------------------------------------------------
// search_text_normalizer
// Streaming search-text normaliser: trims, folds whitespace, lowercases.
// ----------------------------------------------------------------------------
// One byte word in per cycle while the result queue has room; each goes through
// an input register and one stage of logic into a four-word result queue.
// A byte gives up to two result words (owed space or a held 0xC3 plus the
// byte), and the single output word per cycle, while the receiver is ready,
// then sets the pace: input stalls only while the result queue holds more than two words.
// tuser on the output is 0 for a bare end-of-string word with no byte.
`timescale 1ns / 1ps

module search_text_normalizer
  import stn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic             s_axis_tlast_i,  // in_last
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [ByteW-1:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic             m_axis_tuser_o,  // [0] out_valid
  output logic             m_axis_tlast_o   // out_last
);

  push_t push;
  logic  room;
  res_t  res;

  stn_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .room_i     (room),
    .push_o     (push)
  );

  stn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = res.data;
  assign m_axis_tuser_o = res.valid;
  assign m_axis_tlast_o = res.last;

endmodule

/* rtl/stn_core.sv */
// ----------------------------------------------------------------------------
// stn_core
// Input register, string state and the single-pass normalising logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stn_core
  import stn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  input  logic             room_i,
  output push_t            push_o
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             lead_q, lead_d;
  logic             space_q, space_d;
  logic             emitted_q, emitted_d;
  logic             adv;
  logic             take;

  assign adv        = in_valid_q & room_i;
  assign in_ready_o = ~in_valid_q | room_i;
  assign take       = in_valid_i & in_ready_o;
  assign in_valid_d = take | (in_valid_q & ~adv);

  always_comb begin
    logic [ByteW-1:0] f;
    logic             handle;
    logic [1:0]       n;
    res_t             r0, r1;
    f         = fold_trail(in_byte_q);
    handle    = 1'b1;
    n         = 2'd0;
    r0        = '{data: '0, valid: 1'b1, last: 1'b0};
    r1        = '{data: '0, valid: 1'b1, last: 1'b0};
    lead_d    = lead_q;
    space_d   = space_q;
    emitted_d = emitted_q;

    if (lead_q) begin
      lead_d = 1'b0;
      n      = 2'd1;
      if (f != '0) begin
        r0.data = f;
        handle  = 1'b0;
      end else begin
        r0.data = LeadByte;
      end
    end

    if (handle) begin
      if (is_ws(in_byte_q)) begin
        space_d = emitted_q | (n != 2'd0);
      end else begin
        if (space_q) begin
          if (n == 2'd0) r0.data = SpaceByte;
          else           r1.data = SpaceByte;
          n       = n + 2'd1;
          space_d = 1'b0;
        end
        if (in_byte_q == LeadByte && !in_last_q) begin
          lead_d = 1'b1;
        end else begin
          if (n == 2'd0) begin
            r0.data = in_byte_q;
            if (in_byte_q >= UpperLo && in_byte_q <= UpperHi) r0.data = in_byte_q | CaseBit;
          end else begin
            r1.data = in_byte_q;
            if (in_byte_q >= UpperLo && in_byte_q <= UpperHi) r1.data = in_byte_q | CaseBit;
          end
          n = n + 2'd1;
        end
      end
    end

    if (n != 2'd0) emitted_d = 1'b1;

    if (in_last_q) begin
      case (n)
        2'd0: begin
          r0 = '{data: '0, valid: 1'b0, last: 1'b1};
          n  = 2'd1;
        end
        2'd1:    r0.last = 1'b1;
        default: r1.last = 1'b1;
      endcase
      lead_d    = 1'b0;
      space_d   = 1'b0;
      emitted_d = 1'b0;
    end

    push_o.num = adv ? n : 2'd0;
    push_o.e0  = r0;
    push_o.e1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      lead_q     <= 1'b0;
      space_q    <= 1'b0;
      emitted_q  <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (adv) begin
        lead_q    <= lead_d;
        space_q   <= space_d;
        emitted_q <= emitted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

endmodule

/* rtl/stn_queue.sv */
// ----------------------------------------------------------------------------
// stn_queue
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stn_queue
  import stn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop         = (cnt_q != '0) & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign room_o      = cnt_q <= QueueCntW'(QueueDepth - 2);
  assign wr_nx       = wr_q + QueuePtrW'(1);
  assign wr_d        = wr_q + QueuePtrW'(push_i.num);
  assign rd_d        = rd_q + QueuePtrW'(pop);
  assign cnt_d       = cnt_q + QueueCntW'(push_i.num) - QueueCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q]  <= push_i.e0;
    if (push_i.num == 2'd2) mem_q[wr_nx] <= push_i.e1;
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for search_text_normalizer: short directed strings then
// random strings are streamed in with bursty valid and a wandering ready;
// every output word is checked against an in-bench model of the normaliser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import stn_pkg::*;

  localparam int unsigned ItemTarget = 900;
  localparam int unsigned CycLimit   = 200000;
  localparam int unsigned HoldCycles = 250;

  localparam logic [ByteW-1:0] TabByte = 8'h09;
  localparam logic [ByteW-1:0] LfByte  = 8'h0A;
  localparam logic [ByteW-1:0] VtByte  = 8'h0B;
  localparam logic [ByteW-1:0] FfByte  = 8'h0C;
  localparam logic [ByteW-1:0] CrByte  = 8'h0D;

  typedef struct packed {
    logic [ByteW-1:0] chr;
    logic             fin;
  } char_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [ByteW-1:0] s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [ByteW-1:0] m_axis_tdata_o;
  logic             m_axis_tuser_o;
  logic             m_axis_tlast_o;

  search_text_normalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [7:0] in_byte
    .s_axis_tlast_i  (s_tlast),   // in_last
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser_o),  // [0] out_valid
    .m_axis_tlast_o  (m_axis_tlast_o)   // out_last
  );

  always #4 clk_i = ~clk_i;

  char_t raw_q[$];
  res_t  norm_q[$];
  res_t  step_q[$];

  logic held_lead = 1'b0;
  logic owe_space = 1'b0;
  logic sent_any  = 1'b0;

  bit go = 1'b0;
  bit in_fire = 1'b0;
  int cyc = 0;
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_str = 0;
  int n_bare = 0;
  int n_holds = 0;

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return c == SpaceByte || c == TabByte || c == LfByte ||
           c == CrByte || c == FfByte || c == VtByte;
  endfunction

  // trail byte of an accented letter -> plain letter; both halves share a layout but for 0xBF
  function automatic logic [ByteW-1:0] plain_of(input logic [ByteW-1:0] t);
    logic [4:0]       k;
    logic [ByteW-1:0] r;
    k = t[4:0];
    r = '0;
    if (t[7:6] == 2'b10) begin
      case (k) inside
        [5'h00:5'h05]: r = ChA;
        5'h07:         r = ChC;
        [5'h08:5'h0B]: r = ChE;
        [5'h0C:5'h0F]: r = ChI;
        5'h11:         r = ChN;
        [5'h12:5'h16]: r = ChO;
        [5'h19:5'h1C]: r = ChU;
        5'h1D:         r = ChY;
        5'h1F:         r = t[5] ? ChY : '0;
        default:       r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic void emit(input logic [ByteW-1:0] b);
    step_q.insert(step_q.size(), res_t'{data: b, valid: 1'b1, last: 1'b0});
    sent_any = 1'b1;
  endfunction

  function automatic void normalise(input logic [ByteW-1:0] c, input logic fin);
    logic [ByteW-1:0] p;
    logic             open;
    step_q.delete();
    open = 1'b1;
    if (held_lead) begin
      p = plain_of(c);
      held_lead = 1'b0;
      if (p != '0) begin
        emit(p);
        open = 1'b0;
      end else begin
        emit(LeadByte);
      end
    end
    if (open) begin
      if (is_blank(c)) begin
        owe_space = sent_any;
      end else begin
        if (owe_space) begin
          emit(SpaceByte);
          owe_space = 1'b0;
        end
        if (c == LeadByte && !fin) held_lead = 1'b1;
        else if (c >= UpperLo && c <= UpperHi) emit(c | CaseBit);
        else emit(c);
      end
    end
    if (fin) begin
      if (step_q.size() == 0) begin
        step_q.insert(0, res_t'{data: '0, valid: 1'b0, last: 1'b1});
      end else begin
        step_q[step_q.size()-1].last = 1'b1;
      end
      held_lead = 1'b0;
      owe_space = 1'b0;
      sent_any  = 1'b0;
    end
    foreach (step_q[i]) norm_q.insert(norm_q.size(), step_q[i]);
  endfunction

  function automatic logic [ByteW-1:0] pick_char();
    logic [ByteW-1:0] c;
    case ($urandom_range(0, 11))
      0, 1: begin
        case ($urandom_range(0, 5))
          0:       c = TabByte;
          1:       c = LfByte;
          2:       c = VtByte;
          3:       c = FfByte;
          4:       c = CrByte;
          default: c = SpaceByte;
        endcase
      end
      2:       c = SpaceByte;
      3:       c = ByteW'($urandom_range(UpperLo, UpperHi));
      4, 5:    c = ByteW'($urandom_range(8'h21, 8'h7E));
      6, 7:    c = LeadByte;
      8, 9:    c = ByteW'($urandom_range(8'h80, 8'hBF));
      default: c = ByteW'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic void send(input logic [ByteW-1:0] c, input logic fin);
    raw_q.insert(raw_q.size(), char_t'{chr: c, fin: fin});
  endfunction

  // sender: bursts of words with gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin : drv
    char_t w;
    if (go && (!s_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (raw_q.size() > 0) begin
        w = raw_q.pop_front();
        s_tdata  <= w.chr;
        s_tlast  <= w.fin;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches mode now and then; long hold-offs on top
  int hold_left = 0;
  int next_hold = 300;
  int rx_mode = 0;
  int mode_left = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   <= $urandom_range(0, 3);
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (go && n_in >= next_hold) begin
      hold_left <= HoldCycles;
      next_hold <= next_hold + 350;
      n_holds   <= n_holds + 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= $urandom_range(0, 7) != 0;
        default: m_tready <= (cyc % 3) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin : mon
    res_t want;
    cyc <= cyc + 1;
    in_fire <= rst_ni && s_tvalid && s_axis_tready_o;
    if (rst_ni && s_tvalid && s_axis_tready_o) begin
      normalise(s_tdata, s_tlast);
      n_in++;
      if (s_tlast) n_str++;
    end
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      n_out++;
      if (!m_axis_tuser_o) n_bare++;
      if (norm_q.size() == 0) begin
        $error("unexpected word: out_byte %h out_valid %b out_last %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = norm_q.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== want.valid) begin
          $error("out_valid: expected %b, got %b", want.valid, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (cyc == CycLimit);
    $display("timed out after %0d cycles, %0d words still expected", cyc, norm_q.size());
    $display("[search_text_normalizer] ERROR");
    $finish;
  end

  initial begin : stim
    int len;
    // lone blank -> bare end mark; lone 0xC3 -> sent as is
    send(SpaceByte, 1'b1);
    send(LeadByte, 1'b1);
    // leading blank, case edges, 0xC3 before blank, folds, 0xC3 0xC3, trailing blanks
    send(TabByte, 1'b0);
    send(8'h41, 1'b0);
    send(8'h5A, 1'b0);
    send(SpaceByte, 1'b0);
    send(LfByte, 1'b0);
    send(8'h40, 1'b0);
    send(8'h5B, 1'b0);
    send(LeadByte, 1'b0);
    send(SpaceByte, 1'b0);
    send(LeadByte, 1'b0);
    send(8'h80, 1'b0);
    send(LeadByte, 1'b0);
    send(LeadByte, 1'b0);
    send(8'hBF, 1'b0);
    send(LeadByte, 1'b0);
    send(8'h71, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(VtByte, 1'b0);
    send(FfByte, 1'b0);
    send(CrByte, 1'b1);
    while (raw_q.size() < ItemTarget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send(pick_char(), i == len - 1);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    go     <= 1'b1;

    while (raw_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (norm_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (norm_q.size() != 0) begin
      $error("%0d expected words never arrived", norm_q.size());
      errors++;
    end

    $display("covered %0d strings, %0d bytes in, %0d words out (%0d bare end marks)",
             n_str, n_in, n_out, n_bare);
    $display("%0d long receiver hold-offs, %0d cycles, %0d mismatches", n_holds, cyc, errors);
    if (errors == 0) begin
      $display("[search_text_normalizer] OK");
    end else begin
      $display("[search_text_normalizer] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/stn_pkg.sv
rtl/stn_core.sv
rtl/stn_queue.sv
rtl/search_text_normalizer.sv
dv/tb.sv
